// ----- src/terl_pkg.sv -----
// Shared types and constants for the thermal event report limiter.
package terl_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int TOTAL_W         = 32;
    localparam int TIME_W          = 64;
    localparam int INTERVAL_W      = 32;
    localparam int CFG_ADDR_W      = 8;
    localparam int CFG_DATA_W      = 32;
    localparam int NUM_CHAN        = 4;
    localparam int IN_TDATA_W      = 72;
    localparam int OUT_TDATA_W     = 144;

    localparam logic [INTERVAL_W-1:0] CHECK_INTERVAL_RESET = 32'd300000;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_CHECK_INTERVAL = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_POWER_PRESENT  = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PKG_PRESENT    = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_NOTIFY_ENABLE  = 8'd3;

    typedef enum logic [1:0] {
        REPORT_NONE   = 2'd0,
        REPORT_ASSERT = 2'd1,
        REPORT_NORMAL = 2'd2
    } report_t;

    typedef struct packed {
        report_t              report;
        logic [TOTAL_W-1:0]   total;
    } chan_res_t;

    typedef struct packed {
        chan_res_t [NUM_CHAN-1:0] chan;
        logic                     thresh0_notify;
        logic                     thresh1_notify;
    } result_t;

endpackage

// ----- src/terl_chan_lane.sv -----
// One activity channel lane: flag, event count and report rate limiting.
module terl_chan_lane #(
    parameter int COUNT_WIDTH = terl_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            step,
    input  logic                            lane_en,
    input  logic                            bit_in,
    input  logic [terl_pkg::TIME_W-1:0]     now,
    input  logic [terl_pkg::INTERVAL_W-1:0] interval,
    output terl_pkg::chan_res_t             res
);
    import terl_pkg::*;

    logic                   active_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] reported_reg;
    logic [TIME_W-1:0]      next_check_reg;

    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH-1:0] shown;
    logic [TIME_W-1:0]      diff;
    logic                   early;
    logic                   fire;
    logic                   run;
    report_t                report;

    assign count_next = bit_in ? count_reg + COUNT_WIDTH'(1) : count_reg;
    assign diff       = now - next_check_reg;
    assign early      = diff[TIME_W-1];
    assign fire       = !(early && (count_next != reported_reg));
    assign run        = step && lane_en;

    always_comb begin
        report = REPORT_NONE;
        if (lane_en && fire) begin
            if (bit_in) begin
                report = REPORT_ASSERT;
            end else if (active_reg) begin
                report = REPORT_NORMAL;
            end
        end
    end

    // A skipped lane shows the held count
    assign shown = lane_en ? count_next : count_reg;

    generate
        if (COUNT_WIDTH >= TOTAL_W) begin : g_trunc
            assign res.total = shown[TOTAL_W-1:0];
        end else begin : g_ext
            assign res.total = {{(TOTAL_W-COUNT_WIDTH){1'b0}}, shown};
        end
    endgenerate

    assign res.report = report;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= 1'b0;
            count_reg      <= '0;
            reported_reg   <= '0;
            next_check_reg <= '0;
        end else if (run) begin
            active_reg <= bit_in;
            count_reg  <= count_next;
            if (fire) begin
                reported_reg   <= count_next;
                next_check_reg <= now + {{(TIME_W-INTERVAL_W){1'b0}}, interval};
            end
        end
    end

    a_report_syncs: assert property (@(posedge aclk) disable iff (!aresetn)
        (run && fire) |=> (reported_reg == count_reg))
        else $error("reported count not taken on report");

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !run |=> ($stable(count_reg) && $stable(next_check_reg)))
        else $error("lane state moved without a transfer");

endmodule

// ----- src/terl_thresh_lane.sv -----
// One threshold lane: notifications limited by check time.
module terl_thresh_lane (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            step,
    input  logic                            notify_en,
    input  logic                            bit_in,
    input  logic [terl_pkg::TIME_W-1:0]     now,
    input  logic [terl_pkg::INTERVAL_W-1:0] interval,
    output logic                            notify
);
    import terl_pkg::*;

    logic [TIME_W-1:0] next_check_reg;
    logic [TIME_W-1:0] diff;

    assign diff   = now - next_check_reg;
    assign notify = notify_en && bit_in && !diff[TIME_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_check_reg <= '0;
        end else if (step && notify) begin
            next_check_reg <= now + {{(TIME_W-INTERVAL_W){1'b0}}, interval};
        end
    end

endmodule

// ----- src/terl_out_stage.sv -----
// Output register with skid entry so input is still taken while one result waits under backpressure.
module terl_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  terl_pkg::result_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output terl_pkg::result_t   out_data
);
    import terl_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    push;
    logic    main_free;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign main_free = !main_valid_reg || out_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (main_free) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= push;
            end else begin
                main_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (main_free) begin
            if (skid_valid_reg) begin
                main_reg <= skid_reg;
                if (push) begin
                    skid_reg <= in_data;
                end
            end else if (push) begin
                main_reg <= in_data;
            end
        end else if (push) begin
            skid_reg <= in_data;
        end
    end

    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty output register");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && out_ready) |=> main_valid_reg)
        else $error("skid entry lost on drain");

endmodule

// ----- src/thermal_event_report_limiter_top.sv -----
// Top level of the thermal event report limiter.
// Each input transfer's result is registered in the output stage before it appears on m_tdata.
// Throughput: one sample per cycle while s_tready is high; each lane updates its state in the transfer cycle.
// A two-entry output stage keeps s_tready high while one result waits on m_tready.
// Reset (aresetn, synchronous, active low) clears all lane state and output valids,
// and loads the configuration defaults.
module thermal_event_report_limiter_top #(
    parameter int COUNT_WIDTH = terl_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // now_ticks[63:0], core_hot[64], core_power_limited[65], pkg_hot[66],
    // pkg_power_limited[67], thresh0_crossed[68], thresh1_crossed[69], zero pad
    input  logic [terl_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // core_hot_report[1:0], core_power_report[3:2], pkg_hot_report[5:4],
    // pkg_power_report[7:6], thresh0_notify[8], thresh1_notify[9],
    // machine_check_log[10], core_hot_total[42:11], core_power_total[74:43],
    // pkg_hot_total[106:75], pkg_power_total[138:107], zero pad
    output logic [terl_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_wr_en,
    input  logic [terl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [terl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import terl_pkg::*;

    logic [INTERVAL_W-1:0] interval_reg;
    logic                  power_present_reg;
    logic                  pkg_present_reg;
    logic                  notify_en_reg;

    logic                  step;
    logic [TIME_W-1:0]     now;
    logic [NUM_CHAN-1:0]   chan_bits;
    logic [NUM_CHAN-1:0]   chan_en;
    result_t               res;
    result_t               out_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg      <= CHECK_INTERVAL_RESET;
            power_present_reg <= 1'b1;
            pkg_present_reg   <= 1'b1;
            notify_en_reg     <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_CHECK_INTERVAL: interval_reg      <= cfg_wdata[INTERVAL_W-1:0];
                REG_POWER_PRESENT:  power_present_reg <= cfg_wdata[0];
                REG_PKG_PRESENT:    pkg_present_reg   <= cfg_wdata[0];
                REG_NOTIFY_ENABLE:  notify_en_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic in_ready;

    assign s_tready  = in_ready;
    assign step      = s_tvalid && in_ready;
    assign now       = s_tdata[TIME_W-1:0];
    assign chan_bits = s_tdata[TIME_W+NUM_CHAN-1:TIME_W];
    assign chan_en   = {pkg_present_reg && power_present_reg, pkg_present_reg,
                        power_present_reg, 1'b1};

    generate
        for (genvar i = 0; i < NUM_CHAN; i++) begin : g_chan
            terl_chan_lane #(
                .COUNT_WIDTH (COUNT_WIDTH)
            ) u_chan (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .step     (step),
                .lane_en  (chan_en[i]),
                .bit_in   (chan_bits[i]),
                .now      (now),
                .interval (interval_reg),
                .res      (res.chan[i])
            );
        end
    endgenerate

    terl_thresh_lane u_thresh0 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .notify_en (notify_en_reg),
        .bit_in    (s_tdata[TIME_W+NUM_CHAN]),
        .now       (now),
        .interval  (interval_reg),
        .notify    (res.thresh0_notify)
    );

    terl_thresh_lane u_thresh1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .notify_en (notify_en_reg),
        .bit_in    (s_tdata[TIME_W+NUM_CHAN+1]),
        .now       (now),
        .interval  (interval_reg),
        .notify    (res.thresh1_notify)
    );

    terl_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (in_ready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // Merge lane results into the packed result word
    assign m_tdata = {
        5'b0,
        out_res.chan[3].total,
        out_res.chan[2].total,
        out_res.chan[1].total,
        out_res.chan[0].total,
        (out_res.chan[0].report != REPORT_NONE),
        out_res.thresh1_notify,
        out_res.thresh0_notify,
        out_res.chan[3].report,
        out_res.chan[2].report,
        out_res.chan[1].report,
        out_res.chan[0].report
    };

endmodule
